/* rtl/crse_pkg.sv */
// Shared constants and types for the Catmull-Rom spline evaluator.
// Used by every rtl module except crse_ram; no dependencies of its own.
package crse_pkg;

	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = 24;
	localparam int IPART_W    = POS_W - FRAC_BITS;
	localparam int CNT_W      = 9;
	localparam int COORD_W    = 32;
	localparam int PT_W       = 3 * COORD_W;
	// Horner accumulator, wide enough for 12 * 2^31 plus headroom
	localparam int ACC_W      = COORD_W + 8;
	localparam int PROD_W     = ACC_W + FRAC_BITS + 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	// Four neighbour slots and fraction for one evaluation
	typedef struct packed {
		logic [IDX_W-1:0]     k0;
		logic [IDX_W-1:0]     k1;
		logic [IDX_W-1:0]     k2;
		logic [IDX_W-1:0]     k3;
		logic [FRAC_BITS-1:0] u;
	} crse_rd_t;

endpackage

/* rtl/catmull_rom_spline_eval.sv */
// Top level of the uniform Catmull-Rom spline evaluator.
// Depends on crse_pkg, crse_ram, crse_addr, crse_blend.
//
//   channel  direction  handshake                  payload
//   in       to block   in_valid / in_stall        cmd, point_index, point_x/y/z, curve_pos
//   out      from block out_valid / out_stall      out_x/y/z, saturated
//   cfg      to block   cfg_we                     cfg_wdata (point_count)
//
// One item per cycle while in_stall is low; an evaluation's result passes the RAM read and stages s2..s6.
// The point table sits in four copies of a 256 x 96 RAM, one per neighbour read.
// A write item lands in the RAM at its transfer edge; any later evaluation sees it.
// The pipeline holds as a whole while a result waits under out_stall.
// Reset clears stage valid bits and sets point_count to one.
module catmull_rom_spline_eval (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [crse_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic [crse_pkg::IDX_W-1:0]           point_index,
	input  logic signed [crse_pkg::COORD_W-1:0]  point_x,
	input  logic signed [crse_pkg::COORD_W-1:0]  point_y,
	input  logic signed [crse_pkg::COORD_W-1:0]  point_z,
	input  logic [crse_pkg::POS_W-1:0]           curve_pos,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [crse_pkg::COORD_W-1:0]  out_x,
	output logic signed [crse_pkg::COORD_W-1:0]  out_y,
	output logic signed [crse_pkg::COORD_W-1:0]  out_z,
	output logic                                 saturated
);
	import crse_pkg::*;

	logic                 en;
	logic                 xfer;
	logic                 wr;
	crse_rd_t             rd;
	logic [IDX_W-1:0]     raddr [4];
	logic [PT_W-1:0]      rdata [4];
	logic [FRAC_BITS-1:0] u_s1;
	logic [5:0]           v_q;
	logic                 sat_x, sat_y, sat_z;

	assign en       = !(v_q[5] && out_stall);
	assign in_stall = !en;
	assign xfer     = in_valid && en;
	assign wr       = xfer && (cmd == CMD_WRITE);

	crse_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.curve_pos (curve_pos),
		.rd        (rd)
	);

	assign raddr[0] = rd.k0;
	assign raddr[1] = rd.k1;
	assign raddr[2] = rd.k2;
	assign raddr[3] = rd.k3;

	// one table copy per neighbour, all written together
	for (genvar g = 0; g < 4; g++) begin : g_tab
		crse_ram #(.W(PT_W), .D(MAX_POINTS)) u_ram (
			.clk   (clk),
			.we    (wr),
			.waddr (point_index),
			.wdata ({point_x, point_y, point_z}),
			.re    (en),
			.raddr (raddr[g]),
			.rdata (rdata[g])
		);
	end

	// carry the fraction alongside the read
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= rd.u;
		end
	end

	// advance stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], xfer && (cmd == CMD_EVAL)};
		end
	end

	crse_blend u_bx (
		.clk (clk), .en (en),
		.p0 (rdata[0][PT_W-1 -: COORD_W]), .p1 (rdata[1][PT_W-1 -: COORD_W]),
		.p2 (rdata[2][PT_W-1 -: COORD_W]), .p3 (rdata[3][PT_W-1 -: COORD_W]),
		.u_s1 (u_s1), .res_s6 (out_x), .sat_s6 (sat_x)
	);
	crse_blend u_by (
		.clk (clk), .en (en),
		.p0 (rdata[0][2*COORD_W-1 -: COORD_W]), .p1 (rdata[1][2*COORD_W-1 -: COORD_W]),
		.p2 (rdata[2][2*COORD_W-1 -: COORD_W]), .p3 (rdata[3][2*COORD_W-1 -: COORD_W]),
		.u_s1 (u_s1), .res_s6 (out_y), .sat_s6 (sat_y)
	);
	crse_blend u_bz (
		.clk (clk), .en (en),
		.p0 (rdata[0][COORD_W-1:0]), .p1 (rdata[1][COORD_W-1:0]),
		.p2 (rdata[2][COORD_W-1:0]), .p3 (rdata[3][COORD_W-1:0]),
		.u_s1 (u_s1), .res_s6 (out_z), .sat_s6 (sat_z)
	);

	assign out_valid = v_q[5];
	assign saturated = sat_x || sat_y || sat_z;

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
			 out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
			 out_z == 32'sh7fffffff || out_z == 32'sh80000000))
		else $error("saturation flag without a clipped coordinate");
	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cmd == CMD_EVAL) |=> v_q[0])
		else $error("evaluation lost on entry");
	a_write_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !(in_valid && cmd == CMD_EVAL)) |=> !v_q[0])
		else $error("result invented for a write or idle cycle");
endmodule

/* rtl/crse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module crse_ram #(
	parameter int W = 32,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/crse_addr.sv */
// Point count register and neighbour address generation for one evaluation.
// Depends on crse_pkg.
module crse_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [crse_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic [crse_pkg::POS_W-1:0]    curve_pos,
	output crse_pkg::crse_rd_t            rd
);
	import crse_pkg::*;

	logic [IDX_W-1:0]   last_q;
	logic [POS_W-1:0]   pos_end;
	logic [POS_W-1:0]   t;
	logic [IDX_W-1:0]   i;
	logic [IDX_W:0]     i1;
	logic [IDX_W:0]     i2;

	// hold count-1, clamped to the table, so zero acts as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cfg_we) begin
			priority if (cfg_wdata == '0) begin
				last_q <= '0;
			end else if (cfg_wdata > CNT_W'(MAX_POINTS)) begin
				last_q <= IDX_W'(MAX_POINTS - 1);
			end else begin
				last_q <= IDX_W'(cfg_wdata - CNT_W'(1));
			end
		end
	end

	// clamp position to the last point and split it
	always_comb begin
		pos_end = {IPART_W'(last_q), {FRAC_BITS{1'b0}}};
		t       = (curve_pos > pos_end) ? pos_end : curve_pos;
		i       = IDX_W'(t[POS_W-1:FRAC_BITS]);
		i1      = {1'b0, i} + (IDX_W+1)'(1);
		i2      = {1'b0, i} + (IDX_W+1)'(2);
		rd.u    = t[FRAC_BITS-1:0];
		rd.k0   = (i == '0) ? '0 : i - IDX_W'(1);
		rd.k1   = i;
		rd.k2   = (i1 > {1'b0, last_q}) ? last_q : i1[IDX_W-1:0];
		rd.k3   = (i2 > {1'b0, last_q}) ? last_q : i2[IDX_W-1:0];
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(rd.k0 <= rd.k1) && (rd.k1 <= rd.k2) && (rd.k2 <= rd.k3) && (rd.k3 <= last_q))
		else $error("neighbour slots out of order");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(rd.k3 - rd.k0) <= IDX_W'(3))
		else $error("neighbour span too wide");
endmodule

/* rtl/crse_blend.sv */
// Catmull-Rom blend of one coordinate: coefficients, Horner steps, rounding, saturation.
// Depends on crse_pkg. Stages s2..s6, all advanced by en.
module crse_blend (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [crse_pkg::COORD_W-1:0]  p0,
	input  logic signed [crse_pkg::COORD_W-1:0]  p1,
	input  logic signed [crse_pkg::COORD_W-1:0]  p2,
	input  logic signed [crse_pkg::COORD_W-1:0]  p3,
	input  logic [crse_pkg::FRAC_BITS-1:0]       u_s1,
	output logic signed [crse_pkg::COORD_W-1:0]  res_s6,
	output logic                                 sat_s6
);
	import crse_pkg::*;

	logic signed [ACC_W-1:0]  e0, e1, e2, e3;
	logic signed [ACC_W-1:0]  a_s2, b_s2, c_s2, d_s2;
	logic signed [ACC_W-1:0]  a_s3, b_s3, c_s3;
	logic signed [ACC_W-1:0]  a_s4, b_s4;
	logic signed [ACC_W-1:0]  a_s5;
	logic [FRAC_BITS-1:0]     u_s2, u_s3, u_s4;
	logic signed [PROD_W-1:0] m_s3, m_s4, m_s5;
	logic signed [PROD_W-1:0] sh3, sh4, sh5;
	logic signed [ACC_W-1:0]  h4, h5, h6, r6;

	always_comb begin
		e0 = ACC_W'(p0);
		e1 = ACC_W'(p1);
		e2 = ACC_W'(p2);
		e3 = ACC_W'(p3);
	end

	// form the cubic coefficients
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= e1 <<< 1;
			b_s2 <= e2 - e0;
			c_s2 <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			d_s2 <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
			u_s2 <= u_s1;
		end
	end

	// first Horner product
	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= PROD_W'(d_s2 * $signed({1'b0, u_s2}));
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			c_s3 <= c_s2;
			u_s3 <= u_s2;
		end
	end

	// floor shift, add coefficient, multiply again
	always_comb begin
		sh3 = m_s3 >>> FRAC_BITS;
		h4  = ACC_W'(sh3) + c_s3;
		sh4 = m_s4 >>> FRAC_BITS;
		h5  = ACC_W'(sh4) + b_s4;
		sh5 = m_s5 >>> FRAC_BITS;
		h6  = ACC_W'(sh5) + a_s5;
		r6  = (h6 + ACC_W'(1)) >>> 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= PROD_W'(h4 * $signed({1'b0, u_s3}));
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			u_s4 <= u_s3;
			m_s5 <= PROD_W'(h5 * $signed({1'b0, u_s4}));
			a_s5 <= a_s4;
		end
	end

	// round half up and saturate to the coordinate range
	always_ff @(posedge clk) begin
		if (en) begin
			if (r6[ACC_W-1:COORD_W-1] == '0 || r6[ACC_W-1:COORD_W-1] == '1) begin
				res_s6 <= r6[COORD_W-1:0];
				sat_s6 <= 1'b0;
			end else begin
				res_s6 <= r6[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
					: {1'b0, {(COORD_W-1){1'b1}}};
				sat_s6 <= 1'b1;
			end
		end
	end
endmodule

/* dv/catmull_rom_spline_eval_tb.sv */
// Testbench for catmull_rom_spline_eval: directed table, then random point loads and evaluations.
// Depends on crse_pkg and the catmull_rom_spline_eval RTL; predicts each curve point locally.
module catmull_rom_spline_eval_tb;
	import crse_pkg::*;

	localparam int DIRECTED_ROWS = 20;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS = 55;
	localparam logic [COORD_W-1:0] POS_MAX = 32'h7fffffff;
	localparam logic [COORD_W-1:0] NEG_MAX = 32'h80000000;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               sat;
	} curve_pt_t;

	typedef struct {
		logic               c;
		logic [IDX_W-1:0]   idx;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] pz;
		logic [POS_W-1:0]   pos;
		logic               known;
		curve_pt_t          want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_WRITE;
	logic [IDX_W-1:0] point_index = '0;
	logic signed [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic [POS_W-1:0] curve_pos = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] out_x, out_y, out_z;
	logic saturated;

	// Local copy of the point table and the count register
	logic signed [COORD_W-1:0] tab_x [MAX_POINTS];
	logic signed [COORD_W-1:0] tab_y [MAX_POINTS];
	logic signed [COORD_W-1:0] tab_z [MAX_POINTS];
	logic [CNT_W-1:0] count_reg;

	curve_pt_t expected_pts [$];
	int errors = 0;
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	stim_row_t rows [DIRECTED_ROWS];

	catmull_rom_spline_eval dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
			input logic [COORD_W-1:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic logic signed [63:0] fshift(input logic signed [63:0] v);
		return v >>> FRAC_BITS;
	endfunction

	// Blend one coordinate with the Catmull-Rom cubics via Horner, round half up, clamp
	function automatic logic [COORD_W-1:0] blend_coord(input logic signed [63:0] p0,
			input logic signed [63:0] p1, input logic signed [63:0] p2,
			input logic signed [63:0] p3, input logic signed [63:0] u, inout logic sat);
		logic signed [63:0] a, b, c, d, s;
		a = 2 * p1;
		b = p2 - p0;
		c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		d = -p0 + 3 * p1 - 3 * p2 + p3;
		s = fshift(d * u) + c;
		s = fshift(s * u) + b;
		s = fshift(s * u) + a;
		s = (s + 1) >>> 1;
		if (s > 64'sh7fffffff) begin
			sat = 1'b1;
			return POS_MAX;
		end
		if (s < -64'sh80000000) begin
			sat = 1'b1;
			return NEG_MAX;
		end
		return s[COORD_W-1:0];
	endfunction

	function automatic int clamp_slot(input int k, input int n);
		if (k < 0) return 0;
		if (k >= n) return n - 1;
		return k;
	endfunction

	function automatic curve_pt_t eval_curve(input logic [POS_W-1:0] pos);
		curve_pt_t r;
		int n, i, k0, k1, k2, k3;
		logic [31:0] t, lim;
		logic signed [63:0] u;
		n = int'(count_reg);
		if (n < 1) n = 1;
		if (n > MAX_POINTS) n = MAX_POINTS;
		t = 32'(pos);
		lim = (n - 1) << FRAC_BITS;
		if (t > lim) t = lim;
		i = t >> FRAC_BITS;
		u = 64'(t[FRAC_BITS-1:0]);
		k0 = clamp_slot(i - 1, n);
		k1 = clamp_slot(i, n);
		k2 = clamp_slot(i + 1, n);
		k3 = clamp_slot(i + 2, n);
		r.sat = 1'b0;
		r.x = blend_coord(64'(tab_x[k0]), 64'(tab_x[k1]), 64'(tab_x[k2]), 64'(tab_x[k3]),
			u, r.sat);
		r.y = blend_coord(64'(tab_y[k0]), 64'(tab_y[k1]), 64'(tab_y[k2]), 64'(tab_y[k3]),
			u, r.sat);
		r.z = blend_coord(64'(tab_z[k0]), 64'(tab_z[k1]), 64'(tab_z[k2]), 64'(tab_z[k3]),
			u, r.sat);
		return r;
	endfunction

	// Check every result transfer against the oldest expected point
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_pts.size() == 0) begin
				report_mismatch("unexpected result", out_x, '0);
			end else begin
				curve_pt_t w;
				w = expected_pts.pop_front();
				if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
				if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
				if (out_z !== w.z) report_mismatch("out_z", out_z, w.z);
				if (saturated !== w.sat)
					report_mismatch("saturated", COORD_W'(saturated), COORD_W'(w.sat));
			end
		end
	end

	// Receiver stall pattern, plus one long hold-off to fill the pipeline
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				for (n = 0; n < 60; n++) @(posedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 2))
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one item and hold it until transfer; update the local table and expectations
	task automatic send_item(input stim_row_t r);
		in_valid <= 1'b1;
		cmd <= r.c;
		point_index <= r.idx;
		point_x <= r.px;
		point_y <= r.py;
		point_z <= r.pz;
		curve_pos <= r.pos;
		do @(posedge clk); while (in_stall);
		if (r.c == CMD_WRITE) begin
			tab_x[r.idx] = r.px;
			tab_y[r.idx] = r.py;
			tab_z[r.idx] = r.pz;
		end else begin
			curve_pt_t p;
			p = eval_curve(r.pos);
			if (r.known) begin
				if (p.x !== r.want.x) report_mismatch("table row x", p.x, r.want.x);
				if (p.y !== r.want.y) report_mismatch("table row y", p.y, r.want.y);
				if (p.z !== r.want.z) report_mismatch("table row z", p.z, r.want.z);
				if (p.sat !== r.want.sat)
					report_mismatch("table row sat", COORD_W'(p.sat), COORD_W'(r.want.sat));
			end
			expected_pts.push_back(r.known ? r.want : p);
		end
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_and_settle();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (expected_pts.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = v;
	endtask

	function automatic stim_row_t wr_row(input int idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		stim_row_t r;
		r = '{CMD_WRITE, IDX_W'(idx), x, y, z, POS_W'($urandom), 1'b0,
			'{'0, '0, '0, 1'b0}};
		return r;
	endfunction

	function automatic stim_row_t ev_row(input logic [POS_W-1:0] pos);
		stim_row_t r;
		r = '{CMD_EVAL, '0, $urandom, $urandom, $urandom, pos, 1'b0, '{'0, '0, '0, 1'b0}};
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return POS_MAX;
			1: return NEG_MAX;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int k, n, burst, phase, slots;
		stim_row_t r;
		for (k = 0; k < MAX_POINTS; k++) begin
			tab_x[k] = '0;
			tab_y[k] = '0;
			tab_z[k] = '0;
		end
		count_reg = 9'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, clamping of t and neighbours, saturation
		rows[0] = wr_row(0, 32'h00010000, 32'hffff0000, 32'h0);
		rows[1] = ev_row(24'h000000);
		rows[1].known = 1'b1;
		rows[1].want = '{32'h00010000, 32'hffff0000, 32'h0, 1'b0};
		rows[2] = ev_row(24'hffffff);                       // position past end, count one
		rows[2].known = 1'b1;
		rows[2].want = '{32'h00010000, 32'hffff0000, 32'h0, 1'b0};
		rows[3] = wr_row(1, POS_MAX, NEG_MAX, 32'h0);
		rows[4] = wr_row(2, NEG_MAX, POS_MAX, 32'h7fff0000);
		rows[5] = wr_row(3, POS_MAX, NEG_MAX, 32'h80010000);
		rows[6] = wr_row(255, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
		rows[7] = wr_row(254, 32'h0, 32'hffffffff, 32'h1);
		for (k = 8; k < DIRECTED_ROWS; k++) rows[k] = ev_row(POS_W'($urandom));
		rows[8].pos = 24'h000000;
		rows[9].pos = 24'h00ffff;
		rows[10].pos = 24'h018000;
		rows[11].pos = 24'h028000;                           // near saturation
		rows[12].pos = 24'h030000;
		rows[13].pos = 24'hffffff;
		rows[14].pos = 24'h020001;
		for (k = 0; k < 8; k++) send_item(rows[k]);
		drain_and_settle();
		write_count(9'd4);
		for (k = 8; k < 15; k++) send_item(rows[k]);
		drain_and_settle();
		write_count(9'd0);                                   // count zero acts as one
		send_item(rows[15]);
		drain_and_settle();

		// Fill the whole table so every read is of a written slot
		for (k = 0; k < MAX_POINTS; k++) begin
			send_item(wr_row(k, rand_coord(), rand_coord(), rand_coord()));
			if ($urandom_range(0, 7) == 0) drop_valid();
		end
		drain_and_settle();
		write_count(9'd256);
		rows[16] = ev_row(24'hffffff);
		rows[17] = ev_row(24'hff0000);
		rows[18] = ev_row(24'hfeffff);
		rows[19] = ev_row(24'h000001);
		for (k = 16; k < DIRECTED_ROWS; k++) send_item(rows[k]);
		drain_and_settle();
		write_count(9'h1ff);                                 // above table size acts as full
		send_item(ev_row(24'hffffff));
		drain_and_settle();

		// Random phases across several counts, bursts with gaps
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_count(9'd2);
				1: write_count(9'd4);
				2: write_count(CNT_W'($urandom_range(5, 40)));
				3: write_count(9'd256);
				4: write_count(CNT_W'($urandom_range(0, 511)));
				default: write_count(9'd3);
			endcase
			if (phase == 2) long_hold = 1'b1;
			slots = (count_reg == 0) ? 1 : (count_reg > MAX_POINTS ? MAX_POINTS : count_reg);
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(1, 20);
				for (k = 0; k < burst && n < PHASE_ITEMS; k++, n++) begin
					if ($urandom_range(0, 3) == 0)
						r = wr_row($urandom_range(0, 255), rand_coord(), rand_coord(),
							rand_coord());
					else if ($urandom_range(0, 4) == 0)
						r = ev_row(POS_W'($urandom));
					else
						r = ev_row(POS_W'($urandom_range(0, (slots << FRAC_BITS) - 1)));
					send_item(r);
				end
				if ($urandom_range(0, 1)) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			drain_and_settle();
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
